// ===== hw/rtl/stog_pkg.sv =====
// Shared types and constants for the spiral tile order generator.
// No dependencies; compiled first.
package stog_pkg;

   // Configuration register indexes and widths
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WORKER_COUNT = 2'd3;

   localparam int CFG_GRID_W   = 9;
   localparam int CFG_PIX_W    = 13;
   localparam int CFG_WORKER_W = 7;

   localparam logic [CFG_GRID_W-1:0]   GRID_SIZE_RST    = 9'd8;
   localparam logic [CFG_PIX_W-1:0]    IMAGE_WIDTH_RST  = 13'd640;
   localparam logic [CFG_PIX_W-1:0]    IMAGE_HEIGHT_RST = 13'd480;
   localparam logic [CFG_WORKER_W-1:0] WORKER_COUNT_RST = 7'd4;

   // Result field widths
   localparam int TILE_OUT_W   = 8;
   localparam int WORKER_OUT_W = 6;

   // Coordinates behave as 32-bit unsigned counters when they leave the grid
   localparam int COORD_W = 32;

   // Serial divider: product of a 32-bit coordinate and a pixel dimension
   localparam int PROD_W     = COORD_W + CFG_PIX_W;
   localparam int DIV_STEP   = 4;
   localparam int DIV_CYCLES = (PROD_W + DIV_STEP - 1) / DIV_STEP;
   localparam int DVD_W      = DIV_CYCLES * DIV_STEP;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   // Walk headings
   typedef logic [1:0] heading_type;
   localparam heading_type HEAD_RIGHT = 2'd0;
   localparam heading_type HEAD_DOWN  = 2'd1;
   localparam heading_type HEAD_LEFT  = 2'd2;
   localparam heading_type HEAD_UP    = 2'd3;

   // Divider passes
   typedef logic [1:0] pass_type;
   localparam pass_type PASS_X      = 2'd0;
   localparam pass_type PASS_Y      = 2'd1;
   localparam pass_type PASS_WORKER = 2'd2;

   typedef struct packed {
      logic     walk_en;   // advance or restart the walk
      logic     div_load;  // load dividend and divisor for pass
      logic     div_step;  // run one divider step
      logic     div_last;  // final cycle of the pass, capture result
      pass_type pass;
      logic     out_load;  // move result into output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic item_valid;    // current item emits a tile
   } dpath_status_type;

endpackage

// ===== hw/rtl/stog_if.sv =====
// Request and response channel interfaces for the spiral tile order generator.
// Depends on stog_pkg.
interface stog_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface stog_rsp_if #(
   parameter int PIXEL_BITS = 13
);
   import stog_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [PIXEL_BITS-1:0]   pixel_x;
   logic [PIXEL_BITS-1:0]   pixel_y;
   logic [TILE_OUT_W-1:0]   tile_col;
   logic [TILE_OUT_W-1:0]   tile_row;
   logic [WORKER_OUT_W-1:0] worker_id;
   logic                    is_last;
   logic                    valid_res;

   modport source (output valid, output pixel_x, output pixel_y, output tile_col,
                   output tile_row, output worker_id, output is_last, output valid_res,
                   input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input tile_col,
                   input tile_row, input worker_id, input is_last, input valid_res,
                   output ready);
endinterface

// ===== hw/rtl/stog_ctrl.sv =====
// Controller for the spiral tile order generator: sequences walk update,
// three divider passes and the output register. Depends on stog_pkg.
module stog_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  stog_pkg::dpath_status_type status,
   output stog_pkg::ctrl_cmd_type     cmd
);
   import stog_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_RUN  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]           state_ff, state_in;
   pass_type             pass_ff, pass_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 cnt_last;

   assign cnt_last = (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1));

   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.pass  = pass_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.walk_en = 1'b1;
               pass_in     = PASS_X;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            // invalid items skip the divider, all fields go out as zero
            if (!status.item_valid) begin
               state_in = S_OUT;
            end else begin
               cmd.div_load = 1'b1;
               cnt_in       = '0;
               state_in     = S_RUN;
            end
         end
         S_RUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DIV_CNT_W'(1);
            if (cnt_last) begin
               cmd.div_last = 1'b1;
               case (pass_ff)
                  PASS_X: begin
                     pass_in  = PASS_Y;
                     state_in = S_LOAD;
                  end
                  PASS_Y: begin
                     pass_in  = PASS_WORKER;
                     state_in = S_LOAD;
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= PASS_X;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/stog_dpath.sv =====
// Datapath for the spiral tile order generator: walk state, shared serial
// divider and output register. Depends on stog_pkg.
module stog_dpath #(
   parameter int MAX_GRID_SIZE = 256,
   parameter int MAX_WORKERS   = 64,
   parameter int PIXEL_BITS    = 13,
   localparam int GW = $clog2(MAX_GRID_SIZE + 1),
   localparam int WW = $clog2(MAX_WORKERS + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stog_pkg::ctrl_cmd_type               cmd,
   output stog_pkg::dpath_status_type           status,
   input  logic                                 restart,
   input  logic [GW-1:0]                        grid_eff,
   input  logic [WW-1:0]                        workers_eff,
   input  logic [stog_pkg::CFG_PIX_W-1:0]       image_width,
   input  logic [stog_pkg::CFG_PIX_W-1:0]       image_height,
   output logic [PIXEL_BITS-1:0]                pixel_x,
   output logic [PIXEL_BITS-1:0]                pixel_y,
   output logic [stog_pkg::TILE_OUT_W-1:0]      tile_col,
   output logic [stog_pkg::TILE_OUT_W-1:0]      tile_row,
   output logic [stog_pkg::WORKER_OUT_W-1:0]    worker_id,
   output logic                                 is_last,
   output logic                                 valid_res
);
   import stog_pkg::*;

   localparam int CW    = $clog2(MAX_GRID_SIZE) + 3;  // signed coordinate
   localparam int LW    = $clog2(MAX_GRID_SIZE) + 2;  // leg length
   localparam int TW    = 2 * $clog2(MAX_GRID_SIZE);  // tile index
   localparam int DVS_W = (GW > WW) ? GW : WW;
   localparam int RW    = DVS_W + 1;

   // walk state
   logic signed [CW-1:0] col_ff, col_in, row_ff, row_in;
   heading_type          heading_ff, heading_in;
   logic [LW-1:0]        leg_ff, leg_in, steps_ff, steps_in, steps_dec;
   logic [TW-1:0]        tidx_ff, tidx_in;
   logic                 done_ff, done_in;
   logic                 item_valid_ff, item_valid_in;
   logic                 item_last_ff, item_last_in;

   logic [2*GW-1:0]      grid_sq;
   logic [TW-1:0]        last_idx;
   logic [GW-1:0]        half, center;
   logic [COORD_W-1:0]   col32, row32;

   // divider
   logic [DVD_W-1:0]      dvd_ff, dvd_in;
   logic [DVS_W-1:0]      dvs_ff;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [PIXEL_BITS-1:0] quo_ff, quo_in;
   logic [COORD_W-1:0]    mul_a;
   logic [CFG_PIX_W-1:0]  mul_b;
   logic [PROD_W-1:0]     product;

   // per-item results
   logic [PIXEL_BITS-1:0]   px_ff, py_ff;
   logic [WORKER_OUT_W-1:0] wid_ff;

   // output register
   logic [PIXEL_BITS-1:0]   out_px_ff, out_py_ff;
   logic [TILE_OUT_W-1:0]   out_col_ff, out_row_ff;
   logic [WORKER_OUT_W-1:0] out_wid_ff;
   logic                    out_last_ff, out_valid_ff;

   assign grid_sq  = (2*GW)'(grid_eff) * (2*GW)'(grid_eff);
   assign last_idx = TW'(grid_sq - (2*GW)'(1));
   assign half     = grid_eff >> 1;
   assign center   = grid_eff[0] ? half : half - GW'(1);
   assign col32    = COORD_W'(col_ff);
   assign row32    = COORD_W'(row_ff);

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      heading_in    = heading_ff;
      leg_in        = leg_ff;
      steps_in      = steps_ff;
      tidx_in       = tidx_ff;
      done_in       = done_ff;
      item_valid_in = item_valid_ff;
      item_last_in  = item_last_ff;
      steps_dec     = (steps_ff != '0) ? steps_ff - LW'(1) : steps_ff;

      if (cmd.walk_en) begin
         if (restart) begin
            col_in        = CW'(center);
            row_in        = CW'(center);
            heading_in    = HEAD_RIGHT;
            leg_in        = LW'(1);
            steps_in      = LW'(1);
            tidx_in       = '0;
            done_in       = (last_idx == '0);
            item_valid_in = 1'b1;
            item_last_in  = (last_idx == '0);
         end else if (done_ff || tidx_ff >= last_idx) begin
            done_in       = 1'b1;
            item_valid_in = 1'b0;
            item_last_in  = 1'b0;
         end else begin
            case (heading_ff)
               HEAD_RIGHT: col_in = col_ff + CW'(1);
               HEAD_DOWN:  row_in = row_ff + CW'(1);
               HEAD_LEFT:  col_in = col_ff - CW'(1);
               default:    row_in = row_ff - CW'(1);
            endcase
            steps_in = steps_dec;
            if (steps_dec == '0) begin
               heading_in = heading_ff + 2'd1;
               // legs grow after every second turn
               if (!heading_in[0]) begin
                  leg_in = leg_ff + LW'(1);
               end
               steps_in = leg_in;
            end
            tidx_in       = tidx_ff + TW'(1);
            done_in       = (tidx_in == last_idx);
            item_valid_in = 1'b1;
            item_last_in  = (tidx_in == last_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         heading_ff    <= HEAD_RIGHT;
         leg_ff        <= LW'(1);
         steps_ff      <= LW'(1);
         tidx_ff       <= '0;
         done_ff       <= 1'b1;
         item_valid_ff <= 1'b0;
         item_last_ff  <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         heading_ff    <= heading_in;
         leg_ff        <= leg_in;
         steps_ff      <= steps_in;
         tidx_ff       <= tidx_in;
         done_ff       <= done_in;
         item_valid_ff <= item_valid_in;
         item_last_ff  <= item_last_in;
      end
   end

   assign status.item_valid = item_valid_ff;

   // one shared multiplier feeds the divider load
   assign mul_a   = (cmd.pass == PASS_Y) ? row32 : col32;
   assign mul_b   = (cmd.pass == PASS_Y) ? image_height : image_width;
   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

   // restoring division, DIV_STEP quotient bits per cycle, MSB first
   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      for (int k = 0; k < DIV_STEP; k++) begin
         rem_in = {rem_in[RW-2:0], dvd_in[DVD_W-1]};
         dvd_in = {dvd_in[DVD_W-2:0], 1'b0};
         if (rem_in >= {1'b0, dvs_ff}) begin
            rem_in = rem_in - {1'b0, dvs_ff};
            quo_in = {quo_in[PIXEL_BITS-2:0], 1'b1};
         end else begin
            quo_in = {quo_in[PIXEL_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= '0;
         if (cmd.pass == PASS_WORKER) begin
            dvd_ff <= DVD_W'(tidx_ff);
            dvs_ff <= DVS_W'(workers_eff);
         end else begin
            dvd_ff <= DVD_W'(product);
            dvs_ff <= DVS_W'(grid_eff);
         end
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_step && cmd.div_last) begin
         case (cmd.pass)
            PASS_X:  px_ff  <= quo_in;
            PASS_Y:  py_ff  <= quo_in;
            default: wid_ff <= WORKER_OUT_W'(rem_in);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (item_valid_ff) begin
            out_px_ff    <= px_ff;
            out_py_ff    <= py_ff;
            out_col_ff   <= TILE_OUT_W'(col32);
            out_row_ff   <= TILE_OUT_W'(row32);
            out_wid_ff   <= wid_ff;
            out_last_ff  <= item_last_ff;
            out_valid_ff <= 1'b1;
         end else begin
            out_px_ff    <= '0;
            out_py_ff    <= '0;
            out_col_ff   <= '0;
            out_row_ff   <= '0;
            out_wid_ff   <= '0;
            out_last_ff  <= 1'b0;
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign pixel_x   = out_px_ff;
   assign pixel_y   = out_py_ff;
   assign tile_col  = out_col_ff;
   assign tile_row  = out_row_ff;
   assign worker_id = out_wid_ff;
   assign is_last   = out_last_ff;
   assign valid_res = out_valid_ff;

endmodule

// ===== hw/rtl/spiral_tile_order_generator.sv =====
// Spiral tile order generator. Tile items: after the request transfer, the item runs
// three passes (load plus 12 steps) of the shared serial divider, then moves into
// the output register. Items that emit no tile skip the divider and go straight out.
// One item in flight; a finished result waits in the output register while the
// next item is taken, and holds back only the next result until it transfers.
// Reset (synchronous, active high) restores default registers; walk idle until restart.
module spiral_tile_order_generator #(
   parameter int MAX_GRID_SIZE = 256,
   parameter int MAX_WORKERS   = 64,
   parameter int PIXEL_BITS    = 13
) (
   input  logic                             clock,
   input  logic                             reset,
   stog_req_if.sink                         req_ch,
   stog_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [stog_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [stog_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import stog_pkg::*;

   localparam int GW = $clog2(MAX_GRID_SIZE + 1);
   localparam int WW = $clog2(MAX_WORKERS + 1);

   logic [CFG_GRID_W-1:0]   grid_ff;
   logic [CFG_PIX_W-1:0]    width_ff, height_ff;
   logic [CFG_WORKER_W-1:0] workers_ff;
   logic [GW-1:0]           grid_eff;
   logic [WW-1:0]           workers_eff;

   ctrl_cmd_type            cmd;
   dpath_status_type        status;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff    <= GRID_SIZE_RST;
         width_ff   <= IMAGE_WIDTH_RST;
         height_ff  <= IMAGE_HEIGHT_RST;
         workers_ff <= WORKER_COUNT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_SIZE:    grid_ff    <= CFG_GRID_W'(csr_wdata);
            CSR_IMAGE_WIDTH:  width_ff   <= CFG_PIX_W'(csr_wdata);
            CSR_IMAGE_HEIGHT: height_ff  <= CFG_PIX_W'(csr_wdata);
            CSR_WORKER_COUNT: workers_ff <= CFG_WORKER_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // zero counts as one, oversize values saturate
   always_comb begin
      if (grid_ff == '0) begin
         grid_eff = GW'(1);
      end else if (grid_ff > MAX_GRID_SIZE) begin
         grid_eff = GW'(MAX_GRID_SIZE);
      end else begin
         grid_eff = GW'(grid_ff);
      end
      if (workers_ff == '0) begin
         workers_eff = WW'(1);
      end else if (workers_ff > MAX_WORKERS) begin
         workers_eff = WW'(MAX_WORKERS);
      end else begin
         workers_eff = WW'(workers_ff);
      end
   end

   stog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   stog_dpath #(
      .MAX_GRID_SIZE (MAX_GRID_SIZE),
      .MAX_WORKERS   (MAX_WORKERS),
      .PIXEL_BITS    (PIXEL_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .restart      (req_ch.restart),
      .grid_eff     (grid_eff),
      .workers_eff  (workers_eff),
      .image_width  (width_ff),
      .image_height (height_ff),
      .pixel_x      (rsp_ch.pixel_x),
      .pixel_y      (rsp_ch.pixel_y),
      .tile_col     (rsp_ch.tile_col),
      .tile_row     (rsp_ch.tile_row),
      .worker_id    (rsp_ch.worker_id),
      .is_last      (rsp_ch.is_last),
      .valid_res    (rsp_ch.valid_res)
   );

endmodule

// ===== hw/rtl/stog_checker.sv =====
// Port-level checks for the spiral tile order generator, bound to the top.
// Depends on stog_pkg and spiral_tile_order_generator.
module stog_checker #(
   parameter int PIXEL_BITS = 13
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [PIXEL_BITS-1:0]                pixel_x,
   input logic [PIXEL_BITS-1:0]                pixel_y,
   input logic [stog_pkg::TILE_OUT_W-1:0]      tile_col,
   input logic [stog_pkg::TILE_OUT_W-1:0]      tile_row,
   input logic [stog_pkg::WORKER_OUT_W-1:0]    worker_id,
   input logic                                 is_last,
   input logic                                 valid_res
);
   import stog_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous item still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_x) && $stable(pixel_y)
         && $stable(tile_col) && $stable(tile_row) && $stable(worker_id)
         && $stable(is_last) && $stable(valid_res))
      else $error("stalled response changed");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !valid_res |-> pixel_x == '0 && pixel_y == '0 && tile_col == '0
         && tile_row == '0 && worker_id == '0 && !is_last)
      else $error("invalid result carries nonzero fields");

   a_last_is_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_last |-> valid_res)
      else $error("last tile flagged on invalid result");

endmodule

bind spiral_tile_order_generator stog_checker #(.PIXEL_BITS(PIXEL_BITS)) u_stog_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .pixel_x   (rsp_ch.pixel_x),
   .pixel_y   (rsp_ch.pixel_y),
   .tile_col  (rsp_ch.tile_col),
   .tile_row  (rsp_ch.tile_row),
   .worker_id (rsp_ch.worker_id),
   .is_last   (rsp_ch.is_last),
   .valid_res (rsp_ch.valid_res)
);
